[design/rgb_to_yuv420_subsampler_top_defines.svh]
// Assertion macros for the RGB to YUV 4:2:0 subsampler checker.
// No dependencies; included by the checker file.
`ifndef RGB_TO_YUV420_SUBSAMPLER_TOP_DEFINES_SVH
`define RGB_TO_YUV420_SUBSAMPLER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define RGBYUV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgbyuv assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define RGBYUV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgbyuv assertion failed");

`endif

[design/rgbyuv_pkg.sv]
// Shared types, constants and coefficients for the RGB to YUV 4:2:0 subsampler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rgbyuv_pkg;

   localparam int MAX_WIDTH_DEF    = 2048;
   localparam int HEIGHT_PAIRS_MAX = 4096;

   localparam int HALF_WIDTH_W  = 11;
   localparam int HALF_HEIGHT_W = 13;
   localparam int COL_W         = 11;
   localparam int ROW_W         = 13;
   localparam int CSR_DATA_W    = 13;
   localparam int SUM_W         = 10;
   localparam int PROD_W        = 24;

   localparam logic [HALF_WIDTH_W-1:0]  HALF_WIDTH_RST  = 11'd320;
   localparam logic [HALF_HEIGHT_W-1:0] HALF_HEIGHT_RST = 13'd240;

   localparam logic CSR_HALF_WIDTH  = 1'b0;
   localparam logic CSR_HALF_HEIGHT = 1'b1;

   // Q16 BT.601 coefficients
   localparam logic [15:0] COEF_Y_R  = 16'd19595;
   localparam logic [15:0] COEF_Y_G  = 16'd38470;
   localparam logic [15:0] COEF_Y_B  = 16'd7471;
   localparam logic [15:0] COEF_CB_R = 16'd11076;
   localparam logic [15:0] COEF_CB_G = 16'd21692;
   localparam logic [15:0] COEF_CR_G = 16'd27460;
   localparam logic [15:0] COEF_CR_B = 16'd5308;
   localparam logic [15:0] COEF_HALF = 16'd32768;

   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } rgb_sum_type;

   typedef struct packed {
      logic chroma_en;
      logic frame_end;
   } pix_tag_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } line_cmd_type;

endpackage

`default_nettype wire

[design/rgb_to_yuv420_subsampler_top.sv]
// Top level of the RGB to YUV 4:2:0 subsampler: CSRs, raster control, line store, pipeline.
// Uses rgbyuv_pkg, rgbyuv_raster_ctrl, rgbyuv_line_store and rgbyuv_color_pipe.
`timescale 1ns / 1ps
`default_nettype none

// Takes one RGB pixel per clock in raster order while req_stall is low and returns one result
// per pixel: its BT.601 luma, plus Cb/Cr averaged over the 2x2 block on the odd column of
// every odd row, and a frame_end flag on the last pixel. Sustained rate is one pixel per clock
// while rsp_stall is low. A result passes through stage one, which holds the line store read
// and the luma products, stage two, which holds the chroma products, and the output register,
// which holds the Cb/Cr sums after clipping. req_stall rises only while all three
// stages hold results and rsp_stall is high. Per-pair RGB sums of even rows live in a
// single-port line store of MAX_WIDTH/2 entries that has no reset and no clearing pass: each
// entry is written on an even row before the next row reads it.
// half_width and half_height count pixel and row pairs; write them between frames.
module rgb_to_yuv420_subsampler_top
   import rgbyuv_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic [7:0]            req_red,
   input  wire logic [7:0]            req_green,
   input  wire logic [7:0]            req_blue,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [7:0]            rsp_luma,
   output      logic                  rsp_chroma_valid,
   output      logic [7:0]            rsp_blue_diff,
   output      logic [7:0]            rsp_red_diff,
   output      logic                  rsp_frame_end,
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic                  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   logic [HALF_WIDTH_W-1:0]  half_width_ff, half_width_in;
   logic [HALF_HEIGHT_W-1:0] half_height_ff, half_height_in;

   logic         can_accept, accept;
   pix_tag_type  tag;
   line_cmd_type line_cmd;
   logic [IDX_W-1:0] line_idx;
   rgb_sum_type  pair_sum, line_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      half_width_in  = half_width_ff;
      half_height_in = half_height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HALF_WIDTH:  half_width_in  = csr_wdata[HALF_WIDTH_W-1:0];
            CSR_HALF_HEIGHT: half_height_in = csr_wdata[HALF_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff  <= HALF_WIDTH_RST;
         half_height_ff <= HALF_HEIGHT_RST;
      end else begin
         half_width_ff  <= half_width_in;
         half_height_ff <= half_height_in;
      end
   end

   assign req_stall = !can_accept;
   assign accept    = req_valid && can_accept;

   rgbyuv_raster_ctrl #(
      .LINE_DEPTH (LINE_DEPTH),
      .IDX_W      (IDX_W)
   ) u_raster_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .half_width  (half_width_ff),
      .half_height (half_height_ff),
      .red         (req_red),
      .green       (req_green),
      .blue        (req_blue),
      .tag         (tag),
      .line_cmd    (line_cmd),
      .line_idx    (line_idx),
      .pair_sum    (pair_sum)
   );

   rgbyuv_line_store #(
      .DEPTH  (LINE_DEPTH),
      .ADDR_W (IDX_W)
   ) u_line_store (
      .clock (clock),
      .cmd   (line_cmd),
      .addr  (line_idx),
      .wdata (pair_sum),
      .rdata (line_rdata)
   );

   rgbyuv_color_pipe u_color_pipe (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .can_accept       (can_accept),
      .tag              (tag),
      .pair_sum         (pair_sum),
      .line_rdata       (line_rdata),
      .red              (req_red),
      .green            (req_green),
      .blue             (req_blue),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_luma         (rsp_luma),
      .rsp_chroma_valid (rsp_chroma_valid),
      .rsp_blue_diff    (rsp_blue_diff),
      .rsp_red_diff     (rsp_red_diff),
      .rsp_frame_end    (rsp_frame_end)
   );

endmodule

`default_nettype wire

[design/rgbyuv_line_store.sv]
// Single-port line store of per-pair RGB sums with a registered read.
// Uses rgbyuv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbyuv_line_store
   import rgbyuv_pkg::*;
#(
   parameter int DEPTH  = MAX_WIDTH_DEF / 2,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire line_cmd_type      cmd,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire rgb_sum_type       wdata,
   output      rgb_sum_type       rdata
);

   rgb_sum_type mem [DEPTH];
   rgb_sum_type rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[design/rgbyuv_raster_ctrl.sv]
// Raster position tracking, left-pixel hold, pair sums and line store access.
// Uses rgbyuv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbyuv_raster_ctrl
   import rgbyuv_pkg::*;
#(
   parameter int LINE_DEPTH = MAX_WIDTH_DEF / 2,
   parameter int IDX_W      = 10
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic [HALF_WIDTH_W-1:0]  half_width,
   input  wire logic [HALF_HEIGHT_W-1:0] half_height,
   input  wire logic [7:0]               red,
   input  wire logic [7:0]               green,
   input  wire logic [7:0]               blue,
   output      pix_tag_type              tag,
   output      line_cmd_type             line_cmd,
   output      logic [IDX_W-1:0]         line_idx,
   output      rgb_sum_type              pair_sum
);

   localparam logic [12:0] LINE_DEPTH_V = 13'(LINE_DEPTH);
   localparam logic [12:0] HH_MAX_V     = 13'(HEIGHT_PAIRS_MAX);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] pair_ff, pair_in;
   logic [23:0]      left_ff, left_in;

   logic [12:0] hw_eff, hh_eff;
   logic [13:0] col_limit, row_limit;
   logic        row_last, frame_last, col_wrap;
   logic        odd_col, odd_row;

   always_comb begin
      hw_eff = (half_width == '0) ? 13'd1 : {2'b0, half_width};
      if (hw_eff > LINE_DEPTH_V) begin
         hw_eff = LINE_DEPTH_V;
      end
      hh_eff = (half_height == '0) ? 13'd1 : half_height;
      if (hh_eff > HH_MAX_V) begin
         hh_eff = HH_MAX_V;
      end
      col_limit = {hw_eff, 1'b0} - 14'd1;
      row_limit = {hh_eff, 1'b0} - 14'd1;
   end

   assign odd_col    = col_ff[0];
   assign odd_row    = row_ff[0];
   assign row_last   = {3'b0, col_ff} >= col_limit;
   assign frame_last = row_last && ({1'b0, row_ff} >= row_limit);
   assign col_wrap   = row_last || (col_ff == {COL_W{1'b1}});

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      pair_in = pair_ff;
      left_in = left_ff;
      if (accept) begin
         left_in = {red, green, blue};
         col_in  = row_last ? '0 : col_ff + 1'b1;
         if (row_last) begin
            row_in = frame_last ? '0 : row_ff + 1'b1;
         end
         if (col_wrap) begin
            pair_in = '0;
         end else if (odd_col) begin
            pair_in = (pair_ff == IDX_W'(LINE_DEPTH - 1)) ? '0 : pair_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         pair_ff <= '0;
         left_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         pair_ff <= pair_in;
         left_ff <= left_in;
      end
   end

   assign pair_sum.red   = SUM_W'(left_ff[23:16]) + SUM_W'(red);
   assign pair_sum.green = SUM_W'(left_ff[15:8])  + SUM_W'(green);
   assign pair_sum.blue  = SUM_W'(left_ff[7:0])   + SUM_W'(blue);

   assign tag.chroma_en  = odd_col && odd_row;
   assign tag.frame_end  = frame_last;

   assign line_cmd.wr_en = accept && odd_col && !odd_row;
   assign line_cmd.rd_en = accept && odd_col && odd_row;
   assign line_idx       = pair_ff;

endmodule

`default_nettype wire

[design/rgbyuv_color_pipe.sv]
// Three-stage color pipeline: luma, 2x2 chroma average and Cb/Cr, output register.
// Uses rgbyuv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbyuv_color_pipe
   import rgbyuv_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   output      logic        can_accept,
   input  wire pix_tag_type tag,
   input  wire rgb_sum_type pair_sum,
   input  wire rgb_sum_type line_rdata,
   input  wire logic [7:0]  red,
   input  wire logic [7:0]  green,
   input  wire logic [7:0]  blue,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [7:0]  rsp_luma,
   output      logic        rsp_chroma_valid,
   output      logic [7:0]  rsp_blue_diff,
   output      logic [7:0]  rsp_red_diff,
   output      logic        rsp_frame_end
);

   localparam logic signed [25:0] CHROMA_OFFSET = 26'sd8388608;

   function automatic logic [7:0] clip8(input logic signed [25:0] v);
      logic signed [9:0] q;
      begin
         q = v[25:16];
         if (q < 10'sd0) begin
            clip8 = 8'd0;
         end else if (q > 10'sd255) begin
            clip8 = 8'd255;
         end else begin
            clip8 = q[7:0];
         end
      end
   endfunction

   // stage 1
   logic              s1_valid_ff, s1_valid_in;
   pix_tag_type       s1_tag_ff;
   rgb_sum_type       s1_sum_ff;
   logic [PROD_W-1:0] s1_yr_ff, s1_yg_ff, s1_yb_ff;

   // stage 2
   logic              s2_valid_ff, s2_valid_in;
   pix_tag_type       s2_tag_ff;
   logic [7:0]        s2_luma_ff;
   logic [PROD_W-1:0] s2_ur_ff, s2_ug_ff, s2_ub_ff;
   logic [PROD_W-1:0] s2_vr_ff, s2_vg_ff, s2_vb_ff;

   // output register
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_luma_ff, out_cb_ff, out_cr_ff;
   logic              out_cv_ff, out_fe_ff;

   logic adv3, adv2, adv1;
   logic [PROD_W-1:0] luma_sum;
   logic [SUM_W-1:0]  blk_r, blk_g, blk_b;
   logic [7:0]        avg_r, avg_g, avg_b;
   logic signed [25:0] u_sum, v_sum;

   assign adv3       = !out_valid_ff || !rsp_stall;
   assign adv2       = !s2_valid_ff || adv3;
   assign adv1       = !s1_valid_ff || adv2;
   assign can_accept = adv1;

   assign s1_valid_in  = accept ? 1'b1 : (adv2 ? 1'b0 : s1_valid_ff);
   assign s2_valid_in  = adv2 ? s1_valid_ff : s2_valid_ff;
   assign out_valid_in = adv3 ? s2_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tag_ff <= tag;
         s1_sum_ff <= pair_sum;
         s1_yr_ff  <= PROD_W'(red)   * PROD_W'(COEF_Y_R);
         s1_yg_ff  <= PROD_W'(green) * PROD_W'(COEF_Y_G);
         s1_yb_ff  <= PROD_W'(blue)  * PROD_W'(COEF_Y_B);
      end
   end

   // line store data is valid while the item sits in stage 1
   assign luma_sum = s1_yr_ff + s1_yg_ff + s1_yb_ff;
   assign blk_r    = s1_sum_ff.red   + line_rdata.red;
   assign blk_g    = s1_sum_ff.green + line_rdata.green;
   assign blk_b    = s1_sum_ff.blue  + line_rdata.blue;
   assign avg_r    = blk_r[9:2];
   assign avg_g    = blk_g[9:2];
   assign avg_b    = blk_b[9:2];

   always_ff @(posedge clock) begin
      if (adv2 && s1_valid_ff) begin
         s2_tag_ff  <= s1_tag_ff;
         s2_luma_ff <= luma_sum[23:16];
         s2_ur_ff   <= PROD_W'(avg_r) * PROD_W'(COEF_CB_R);
         s2_ug_ff   <= PROD_W'(avg_g) * PROD_W'(COEF_CB_G);
         s2_ub_ff   <= PROD_W'(avg_b) * PROD_W'(COEF_HALF);
         s2_vr_ff   <= PROD_W'(avg_r) * PROD_W'(COEF_HALF);
         s2_vg_ff   <= PROD_W'(avg_g) * PROD_W'(COEF_CR_G);
         s2_vb_ff   <= PROD_W'(avg_b) * PROD_W'(COEF_CR_B);
      end
   end

   assign u_sum = CHROMA_OFFSET + $signed({2'b0, s2_ub_ff})
                  - $signed({2'b0, s2_ur_ff}) - $signed({2'b0, s2_ug_ff});
   assign v_sum = CHROMA_OFFSET + $signed({2'b0, s2_vr_ff})
                  - $signed({2'b0, s2_vg_ff}) - $signed({2'b0, s2_vb_ff});

   always_ff @(posedge clock) begin
      if (adv3 && s2_valid_ff) begin
         out_luma_ff <= s2_luma_ff;
         out_cv_ff   <= s2_tag_ff.chroma_en;
         out_fe_ff   <= s2_tag_ff.frame_end;
         out_cb_ff   <= s2_tag_ff.chroma_en ? clip8(u_sum) : 8'd0;
         out_cr_ff   <= s2_tag_ff.chroma_en ? clip8(v_sum) : 8'd0;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_luma         = out_luma_ff;
   assign rsp_chroma_valid = out_cv_ff;
   assign rsp_blue_diff    = out_cb_ff;
   assign rsp_red_diff     = out_cr_ff;
   assign rsp_frame_end    = out_fe_ff;

endmodule

`default_nettype wire

[design/rgbyuv_checker.sv]
// Port-level checker for the RGB to YUV 4:2:0 subsampler, bound to the top level.
// Uses rgb_to_yuv420_subsampler_top_defines.svh and rgbyuv_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_yuv420_subsampler_top_defines.svh"

module rgbyuv_checker
   import rgbyuv_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_luma,
   input wire logic       rsp_chroma_valid,
   input wire logic [7:0] rsp_blue_diff,
   input wire logic [7:0] rsp_red_diff,
   input wire logic       rsp_frame_end
);

   logic out_held;
   logic rsp_free;

   assign out_held = rsp_valid && rsp_stall;
   assign rsp_free = !rsp_valid || !rsp_stall;

   `RGBYUV_ASSERT_NEXT(a_rsp_valid_holds, clock, reset, out_held, rsp_valid)
   `RGBYUV_ASSERT_NEXT(a_rsp_payload_holds, clock, reset, out_held,
      $stable(rsp_luma) && $stable(rsp_chroma_valid) && $stable(rsp_blue_diff) &&
      $stable(rsp_red_diff) && $stable(rsp_frame_end))
   `RGBYUV_ASSERT_NOW(a_no_chroma_is_zero, clock, reset, rsp_valid && !rsp_chroma_valid,
      rsp_blue_diff == 8'd0 && rsp_red_diff == 8'd0)
   `RGBYUV_ASSERT_NEXT(a_no_stall_when_drained, clock, reset,
      rsp_free && !req_valid && !$past(req_valid) && !$past(req_valid, 2), !req_stall)

endmodule

bind rgb_to_yuv420_subsampler_top rgbyuv_checker u_rgbyuv_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_luma         (rsp_luma),
   .rsp_chroma_valid (rsp_chroma_valid),
   .rsp_blue_diff    (rsp_blue_diff),
   .rsp_red_diff     (rsp_red_diff),
   .rsp_frame_end    (rsp_frame_end)
);

`default_nettype wire
